FILE: rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants for the step sequencer track
// Run modes, item function codes, register indexes, FSM states, CV limits.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

  localparam int STEPS_DEF = 32;
  localparam int MOD_W_DEF = 6;
  localparam int CV_W      = 13;

  localparam logic signed [CV_W-1:0] CV_RESET = -13'sd2400;
  localparam logic signed [CV_W-1:0] CV_MAX   = 13'sd3600;
  localparam logic signed [CV_W-1:0] CV_MIN   = -13'sd3600;

  // round-to-semitone: floor(x / 100) = (x * 5243) >> 19 for x < 43690
  localparam int          QUANT_SHIFT = 19;
  localparam logic [12:0] QUANT_RECIP = 13'd5243;
  localparam logic [13:0] QUANT_HALF  = 14'd50;
  localparam logic [6:0]  SEMITONE    = 7'd100;

  localparam logic [5:0]  LOOP_LEN_RST = 6'd8;
  localparam logic [4:0]  START_RST    = 5'd0;
  localparam logic [3:0]  STRIDE_RST   = 4'd1;
  localparam logic [31:0] GATE_RST     = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    MODE_FWD       = 3'd0,
    MODE_BWD       = 3'd1,
    MODE_PING_PONG = 3'd2,
    MODE_RND_WALK  = 3'd3,
    MODE_RND_JUMP  = 3'd4
  } run_mode_t;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_RESTART = 2'd1,
    FUNC_WRITE   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    REG_RUN_MODE    = 3'd0,
    REG_LOOP_LEN    = 3'd1,
    REG_START       = 3'd2,
    REG_STRIDE      = 3'd3,
    REG_GATE        = 3'd4,
    REG_SAMPLE_HOLD = 3'd5,
    REG_QUANTIZE    = 3'd6,
    REG_TRACK_EN    = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD_S,
    ST_MOD_A,
    ST_MOD_R,
    ST_STEP,
    ST_CUR_GO,
    ST_MOD_CUR,
    ST_READ,
    ST_QNT,
    ST_HOLD
  } state_t;

  typedef enum logic [1:0] {
    SRC_CNT,
    SRC_STRIDE,
    SRC_RSTEP
  } mod_src_t;

  function automatic logic signed [CV_W-1:0] sat_cv(input logic signed [CV_W-1:0] v);
    logic signed [CV_W-1:0] r;
    r = v;
    if (v > CV_MAX) r = CV_MAX;
    if (v < CV_MIN) r = CV_MIN;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cyclic_step_sequencer_track.sv
// ----------------------------------------------------------------------------
// cyclic_step_sequencer_track: one track of a cyclic step sequencer
// Remainder width DW = max(log2 STEPS, 5) + 1. A tick in modes 0-3 reduces the
// counter and then the stride in the remainder unit; a random jump reduces the
// random step, other items skip it; below 32 steps, repeated subtraction of STEPS
// wraps the step index. One item at a time; in_stall holds until the output loads.
// Sync reset: counter, direction and held CV zero, table reads -2400 until written.
// ----------------------------------------------------------------------------
`default_nettype none

module cyclic_step_sequencer_track import cst_pkg::*; #(
  parameter int STEPS = STEPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [31:0]            cfg_data,

  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_func,
  input  wire logic                   in_random_bit,
  input  wire logic [4:0]             in_random_step,
  input  wire logic [4:0]             in_table_index,
  input  wire logic signed [CV_W-1:0] in_table_value,

  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [4:0]                  out_current_step,
  output logic                        out_gate,
  output logic signed [CV_W-1:0]      out_cv_out,
  output logic                        out_advanced
);

  localparam int CW = $clog2(STEPS);
  localparam int NW = $clog2(STEPS + 1);
  localparam int DW = ((CW > 5) ? CW : 5) + 1;

  // configuration
  run_mode_t   run_mode_r;
  logic [5:0]  loop_len_r;
  logic [4:0]  start_r;
  logic [3:0]  stride_r;
  logic [31:0] gate_r;
  logic        shold_r;
  logic        quant_r;
  logic        en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mode_r <= MODE_FWD;
      loop_len_r <= LOOP_LEN_RST;
      start_r    <= START_RST;
      stride_r   <= STRIDE_RST;
      gate_r     <= GATE_RST;
      shold_r    <= 1'b0;
      quant_r    <= 1'b0;
      en_r       <= 1'b1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_RUN_MODE:    run_mode_r <= run_mode_t'(cfg_data[2:0]);
        REG_LOOP_LEN:    loop_len_r <= cfg_data[5:0];
        REG_START:       start_r    <= cfg_data[4:0];
        REG_STRIDE:      stride_r   <= cfg_data[3:0];
        REG_GATE:        gate_r     <= cfg_data;
        REG_SAMPLE_HOLD: shold_r    <= cfg_data[0];
        REG_QUANTIZE:    quant_r    <= cfg_data[0];
        REG_TRACK_EN:    en_r       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // state and datapath registers
  state_t                 state_r;
  state_t                 state_nxt;
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          cnt_nxt;
  logic                   dir_r;
  logic                   dir_nxt;
  logic signed [CV_W-1:0] held_cv_r;
  logic signed [CV_W-1:0] held_cv_nxt;
  logic                   adv_r;
  logic                   rbit_r;
  logic [CW-1:0]          sm_r;
  logic [CW-1:0]          am_r;
  logic [DW-1:0]          cur_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [4:0]             out_step_r;
  logic                   out_gate_r;
  logic signed [CV_W-1:0] out_cv_r;
  logic                   out_adv_r;

  logic                   in_acc;
  func_t                  func_w;
  logic                   out_free;
  logic [NW-1:0]          n_eff;
  logic [3:0]             stride_eff;
  logic                   mod_go;
  mod_src_t               mod_src;
  logic [DW-1:0]          mod_dvd;
  logic [DW-1:0]          mod_dvs;
  logic                   mod_done;
  logic [DW-1:0]          mod_rem;
  logic [DW-1:0]          sum_w;
  logic [DW-1:0]          fwd_w;
  logic [DW-1:0]          bwd_w;
  logic [CW-1:0]          fwd_c;
  logic [CW-1:0]          bwd_c;
  logic [CW-1:0]          rst_cnt;
  logic [DW-1:0]          cur_sum;
  logic [DW-1:0]          cur_wrap;
  logic                   tbl_we;
  logic                   gate_w;
  logic signed [CV_W-1:0] q_cv;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign func_w   = func_t'(in_func);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (loop_len_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(loop_len_r) > STEPS) begin
      n_eff = NW'(STEPS);
    end else begin
      n_eff = NW'(loop_len_r);
    end
    if (stride_r == 4'd0) begin
      stride_eff = 4'd1;
    end else if (stride_r > 4'd8) begin
      stride_eff = 4'd8;
    end else begin
      stride_eff = stride_r;
    end
  end

  // remainder unit operands
  always_comb begin
    case (mod_src)
      SRC_CNT:    mod_dvd = DW'(cnt_r);
      SRC_STRIDE: mod_dvd = DW'(stride_eff);
      SRC_RSTEP:  mod_dvd = DW'(in_random_step);
      default:    mod_dvd = '0;
    endcase
  end

  assign mod_dvs = DW'(n_eff);

  cst_mod_unit #(
    .DW (DW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (mod_go),
    .dividend (mod_dvd),
    .divisor  (mod_dvs),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // forward and backward moves from reduced counter and stride
  always_comb begin
    sum_w = DW'(sm_r) + DW'(am_r);
    if (sum_w >= DW'(n_eff)) begin
      fwd_w = sum_w - DW'(n_eff);
    end else begin
      fwd_w = sum_w;
    end
    if (sm_r >= am_r) begin
      bwd_w = DW'(sm_r) - DW'(am_r);
    end else begin
      bwd_w = DW'(sm_r) + DW'(n_eff) - DW'(am_r);
    end
    fwd_c = CW'(fwd_w);
    bwd_c = CW'(bwd_w);
  end

  // current step: offset plus counter, wrapped by compare and subtract
  always_comb begin
    cur_sum = DW'(start_r) + DW'(cnt_r);
    if (cur_sum >= DW'(STEPS)) begin
      cur_wrap = cur_sum - DW'(STEPS);
    end else begin
      cur_wrap = cur_sum;
    end
  end

  always_comb begin
    case (run_mode_r)
      MODE_FWD, MODE_PING_PONG, MODE_RND_WALK: rst_cnt = '0;
      MODE_BWD: rst_cnt = CW'(n_eff - NW'(1));
      default:  rst_cnt = cnt_r;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    dir_nxt = dir_r;
    if (in_acc && en_r && (func_w == FUNC_RESTART)) begin
      cnt_nxt = rst_cnt;
    end else if (state_r == ST_STEP) begin
      case (run_mode_r)
        MODE_FWD: cnt_nxt = fwd_c;
        MODE_BWD: cnt_nxt = bwd_c;
        MODE_PING_PONG: begin
          if (dir_r) begin
            if (bwd_c > cnt_r) begin
              cnt_nxt = fwd_c;
              dir_nxt = 1'b0;
            end else begin
              cnt_nxt = bwd_c;
            end
          end else begin
            if (fwd_c < cnt_r) begin
              cnt_nxt = bwd_c;
              dir_nxt = 1'b1;
            end else begin
              cnt_nxt = fwd_c;
            end
          end
        end
        MODE_RND_WALK: cnt_nxt = rbit_r ? fwd_c : bwd_c;
        MODE_RND_JUMP: cnt_nxt = sm_r;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mod_go    = 1'b0;
    mod_src   = SRC_CNT;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CUR_GO;
          if (en_r && (func_w == FUNC_TICK)) begin
            case (run_mode_r)
              MODE_FWD, MODE_BWD, MODE_PING_PONG, MODE_RND_WALK: begin
                mod_go    = 1'b1;
                mod_src   = SRC_CNT;
                state_nxt = ST_MOD_S;
              end
              MODE_RND_JUMP: begin
                mod_go    = 1'b1;
                mod_src   = SRC_RSTEP;
                state_nxt = ST_MOD_R;
              end
              default: state_nxt = ST_CUR_GO;
            endcase
          end
        end
      end
      ST_MOD_S: begin
        if (mod_done) begin
          mod_go    = 1'b1;
          mod_src   = SRC_STRIDE;
          state_nxt = ST_MOD_A;
        end
      end
      ST_MOD_A: begin
        if (mod_done) begin
          state_nxt = ST_STEP;
        end
      end
      ST_MOD_R: begin
        if (mod_done) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP:   state_nxt = ST_CUR_GO;
      ST_CUR_GO: state_nxt = ST_MOD_CUR;
      ST_MOD_CUR: begin
        if (cur_r < DW'(STEPS)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_QNT;
      ST_QNT:  state_nxt = ST_HOLD;
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // CV table and quantizer
  assign tbl_we = in_acc && (func_w == FUNC_WRITE) && (int'(in_table_index) < STEPS);

  logic signed [CV_W-1:0] rd_cv;

  cst_cv_mem #(
    .STEPS (STEPS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_we),
    .wr_addr (CW'(in_table_index)),
    .wr_data (sat_cv(in_table_value)),
    .rd_en   (state_r == ST_READ),
    .rd_addr (CW'(cur_r)),
    .rd_data (rd_cv)
  );

  cst_quant u_quant (
    .clk  (clk),
    .ld   (state_r == ST_QNT),
    .qen  (quant_r),
    .din  (rd_cv),
    .dout (q_cv)
  );

  assign gate_w = (int'(cur_r) < 32) ? gate_r[5'(cur_r)] : 1'b0;

  always_comb begin
    held_cv_nxt = held_cv_r;
    if ((state_r == ST_HOLD) && out_free && adv_r && (!shold_r || gate_w)) begin
      held_cv_nxt = q_cv;
    end
  end

  assign out_valid_nxt = (state_r == ST_HOLD) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      dir_r       <= 1'b0;
      held_cv_r   <= '0;
      adv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dir_r       <= dir_nxt;
      held_cv_r   <= held_cv_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        adv_r <= en_r && ((func_w == FUNC_TICK) || (func_w == FUNC_RESTART));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rbit_r <= in_random_bit;
    end
    if (mod_done) begin
      case (state_r)
        ST_MOD_S: sm_r <= CW'(mod_rem);
        ST_MOD_A: am_r <= CW'(mod_rem);
        ST_MOD_R: sm_r <= CW'(mod_rem);
        default: begin
        end
      endcase
    end
    if (state_r == ST_CUR_GO) begin
      cur_r <= cur_wrap;
    end else if ((state_r == ST_MOD_CUR) && (cur_r >= DW'(STEPS))) begin
      cur_r <= cur_r - DW'(STEPS);
    end
    if ((state_r == ST_HOLD) && out_free) begin
      out_step_r <= 5'(cur_r);
      out_gate_r <= en_r && gate_w;
      out_cv_r   <= en_r ? held_cv_nxt : '0;
      out_adv_r  <= adv_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_current_step = out_step_r;
  assign out_gate         = out_gate_r;
  assign out_cv_out       = out_cv_r;
  assign out_advanced     = out_adv_r;

endmodule

`default_nettype wire

FILE: rtl/cst_mod_unit.sv
// ----------------------------------------------------------------------------
// cst_mod_unit: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; remainder valid with done.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_mod_unit import cst_pkg::*; #(
  parameter  int DW  = MOD_W_DEF,
  localparam int CTW = $clog2(DW + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      rem
);

  logic           busy_r;
  logic           done_r;
  logic [CTW-1:0] cnt_r;
  logic [DW-1:0]  sh_r;
  logic [DW-1:0]  div_r;
  logic [DW-1:0]  rem_r;
  logic [DW:0]    part;
  logic [DW:0]    dvs_ext;
  logic [DW-1:0]  rem_nxt;
  logic           load;

  assign load    = go && !busy_r;
  assign part    = {rem_r, sh_r[DW-1]};
  assign dvs_ext = {1'b0, div_r};

  always_comb begin
    if (part >= dvs_ext) begin
      rem_nxt = DW'(part - dvs_ext);
    end else begin
      rem_nxt = DW'(part);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CTW'(1));
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= CTW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CTW'(1);
        if (cnt_r == CTW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh_r  <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= sh_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: rtl/cst_cv_mem.sv
// ----------------------------------------------------------------------------
// cst_cv_mem: CV table memory
// One write and one registered read port; unwritten entries read as -2400.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_cv_mem import cst_pkg::*; #(
  parameter  int STEPS = STEPS_DEF,
  localparam int AW    = $clog2(STEPS)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic signed [CV_W-1:0] wr_data,
  input  wire logic                   rd_en,
  input  wire logic [AW-1:0]          rd_addr,
  output logic signed [CV_W-1:0]      rd_data
);

  logic signed [CV_W-1:0] mem_r [STEPS];
  logic [STEPS-1:0]       vld_r;
  logic signed [CV_W-1:0] rdat_r;
  logic                   rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdat_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdat_r : CV_RESET;

endmodule

`default_nettype wire

FILE: rtl/cst_quant.sv
// ----------------------------------------------------------------------------
// cst_quant: semitone quantizer
// Rounds cents to a multiple of 100, half away from zero; one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_quant import cst_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   ld,
  input  wire logic                   qen,
  input  wire logic signed [CV_W-1:0] din,
  output logic signed [CV_W-1:0]      dout
);

  localparam int PW = 27;

  logic [CV_W-1:0]             absv;
  logic [13:0]                 mag;
  logic [PW-1:0]               prod_r;
  logic                        neg_r;
  logic                        qen_r;
  logic signed [CV_W-1:0]      raw_r;
  logic [PW-QUANT_SHIFT-1:0]   q;
  logic [13:0]                 m;
  logic signed [CV_W-1:0]      mq;

  always_comb begin
    if (din[CV_W-1]) begin
      absv = CV_W'(-din);
    end else begin
      absv = CV_W'(din);
    end
    mag = {1'b0, absv} + QUANT_HALF;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      prod_r <= PW'(mag) * PW'(QUANT_RECIP);
      neg_r  <= din[CV_W-1];
      qen_r  <= qen;
      raw_r  <= din;
    end
  end

  always_comb begin
    q  = prod_r[PW-1:QUANT_SHIFT];
    m  = 14'(q) * 14'(SEMITONE);
    mq = signed'(m[CV_W-1:0]);
    if (!qen_r) begin
      dout = raw_r;
    end else if (neg_r) begin
      dout = -mq;
    end else begin
      dout = mq;
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_cyclic_step_sequencer_track.sv
// ----------------------------------------------------------------------------
// tb_cyclic_step_sequencer_track: self-checking bench for one sequencer track
// A directed table of items and register writes runs first. Randomized phases
// of register settings and items follow, with random input gaps and output
// stalls. Results are checked against fixed expectations or an in-bench model of
// the counter, the run modes, the CV table and the hold register.
// ----------------------------------------------------------------------------

module tb_cyclic_step_sequencer_track;
  import cst_pkg::*;

  localparam int         HALF_PERIOD  = 6;
  localparam int         SETTLE_CYC   = 40;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         TARGET_ITEMS = 450;
  localparam logic [1:0] FUNC_NOP     = 2'd3;
  localparam logic [2:0] MODE_UNUSED  = 3'd7;

  typedef struct packed {
    logic [4:0]             step;
    logic                   gate;
    logic signed [CV_W-1:0] cv;
    logic                   adv;
  } track_out_t;

  typedef struct {
    bit                     is_reg;
    reg_idx_t               idx;
    logic [31:0]            data;
    logic [1:0]             func;
    logic                   rbit;
    logic [4:0]             rstep;
    logic [4:0]             tidx;
    logic signed [CV_W-1:0] tval;
    bit                     typed;
    track_out_t             want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [2:0]             cfg_index;
  logic [31:0]            cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             in_func;
  logic                   in_random_bit;
  logic [4:0]             in_random_step;
  logic [4:0]             in_table_index;
  logic signed [CV_W-1:0] in_table_value;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [4:0]             out_current_step;
  logic                   out_gate;
  logic signed [CV_W-1:0] out_cv_out;
  logic                   out_advanced;

  // track model
  logic [2:0]             m_mode;
  logic [5:0]             m_len;
  logic [4:0]             m_start;
  logic [3:0]             m_stride;
  logic [31:0]            m_gates;
  logic                   m_hold;
  logic                   m_quant;
  logic                   m_en;
  logic [4:0]             m_cnt;
  logic                   m_back;
  logic signed [CV_W-1:0] m_held;
  logic signed [CV_W-1:0] m_table [32];

  track_out_t             pending_q[$];
  track_out_t             seen_want;
  stim_row_t              rows[$];
  int                     errors = 0;
  int                     cycles = 0;
  int                     stall_left = 0;
  int                     stall_draw;
  bit                     calm = 1'b0;

  cyclic_step_sequencer_track u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_random_bit    (in_random_bit),
    .in_random_step   (in_random_step),
    .in_table_index   (in_table_index),
    .in_table_value   (in_table_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_current_step (out_current_step),
    .out_gate         (out_gate),
    .out_cv_out       (out_cv_out),
    .out_advanced     (out_advanced)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int loop_n();
    return (m_len == 0) ? 1 : (m_len > 32) ? 32 : int'(m_len);
  endfunction

  function automatic int step_fwd(int s, int n, int a);
    return ((s % n) + (a % n)) % n;
  endfunction

  function automatic int step_bwd(int s, int n, int a);
    return ((s % n) + n - (a % n)) % n;
  endfunction

  function automatic track_out_t track_predict(logic [1:0] f, logic rb, logic [4:0] rs,
                                               logic [4:0] ti, logic signed [CV_W-1:0] tv);
    track_out_t r;
    int         n;
    int         a;
    int         c;
    int         t;
    int         v;
    int         cur;
    bit         adv;
    n   = loop_n();
    a   = (m_stride == 0) ? 1 : (m_stride > 8) ? 8 : int'(m_stride);
    c   = int'(m_cnt);
    adv = 1'b0;
    if (f == FUNC_WRITE) begin
      v = int'(tv);
      if (v > 3600) v = 3600;
      if (v < -3600) v = -3600;
      m_table[ti] = v[CV_W-1:0];
    end else if (m_en && f == FUNC_TICK) begin
      adv = 1'b1;
      case (m_mode)
        MODE_FWD: c = step_fwd(c, n, a);
        MODE_BWD: c = step_bwd(c, n, a);
        MODE_PING_PONG: begin
          if (m_back) begin
            t = step_bwd(c, n, a);
            if (t > c) begin
              c = step_fwd(c, n, a);
              m_back = 1'b0;
            end else begin
              c = t;
            end
          end else begin
            t = step_fwd(c, n, a);
            if (t < c) begin
              c = step_bwd(c, n, a);
              m_back = 1'b1;
            end else begin
              c = t;
            end
          end
        end
        MODE_RND_WALK: c = rb ? step_fwd(c, n, a) : step_bwd(c, n, a);
        MODE_RND_JUMP: c = int'(rs) % n;
        default: ;
      endcase
    end else if (m_en && f == FUNC_RESTART) begin
      adv = 1'b1;
      case (m_mode)
        MODE_FWD, MODE_PING_PONG, MODE_RND_WALK: c = 0;
        MODE_BWD: c = n - 1;
        default: ;
      endcase
    end
    m_cnt = c[4:0];
    cur   = (int'(m_start) + c) % 32;
    if (adv && (!m_hold || m_gates[cur])) begin
      v = int'(m_table[cur]);
      if (m_quant) begin
        if (v >= 0) v = ((v + 50) / 100) * 100;
        else v = -(((-v + 50) / 100) * 100);
      end
      m_held = v[CV_W-1:0];
    end
    r.step = cur[4:0];
    r.gate = m_en & m_gates[cur];
    r.cv   = m_en ? m_held : '0;
    r.adv  = adv;
    return r;
  endfunction

  function automatic stim_row_t op_row(logic [1:0] f, logic rb, logic [4:0] rs,
                                       logic [4:0] ti, logic signed [CV_W-1:0] tv);
    stim_row_t r;
    r.is_reg = 1'b0;
    r.idx    = REG_RUN_MODE;
    r.data   = '0;
    r.func   = f;
    r.rbit   = rb;
    r.rstep  = rs;
    r.tidx   = ti;
    r.tval   = tv;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic stim_row_t want_row(stim_row_t r, logic [4:0] s, logic g,
                                         logic signed [CV_W-1:0] cv, logic adv);
    r.typed     = 1'b1;
    r.want.step = s;
    r.want.gate = g;
    r.want.cv   = cv;
    r.want.adv  = adv;
    return r;
  endfunction

  function automatic stim_row_t reg_row(reg_idx_t i, logic [31:0] d);
    stim_row_t r;
    r        = op_row(FUNC_NOP, 1'b0, '0, '0, '0);
    r.is_reg = 1'b1;
    r.idx    = i;
    r.data   = d;
    return r;
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t i, logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= i;
    cfg_data  <= d;
    @(posedge clk);
    case (i)
      REG_RUN_MODE:    m_mode   = d[2:0];
      REG_LOOP_LEN:    m_len    = d[5:0];
      REG_START:       m_start  = d[4:0];
      REG_STRIDE:      m_stride = d[3:0];
      REG_GATE:        m_gates  = d;
      REG_SAMPLE_HOLD: m_hold   = d[0];
      REG_QUANTIZE:    m_quant  = d[0];
      REG_TRACK_EN:    m_en     = d[0];
      default: ;
    endcase
  endtask

  task automatic send_item(logic [1:0] f, logic rb, logic [4:0] rs, logic [4:0] ti,
                           logic signed [CV_W-1:0] tv, output track_out_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_random_bit  <= rb;
    in_random_step <= rs;
    in_table_index <= ti;
    in_table_value <= tv;
    do @(posedge clk); while (in_stall);
    r = track_predict(f, rb, rs, ti, tv);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected item step=%0d gate=%0b cv=%0d adv=%0b", $time,
                 out_current_step, out_gate, out_cv_out, out_advanced);
        errors++;
      end else begin
        seen_want = pending_q.pop_front();
        if (out_current_step !== seen_want.step) begin
          $display("%0t: current_step expected %0d actual %0d", $time,
                   seen_want.step, out_current_step);
          errors++;
        end
        if (out_gate !== seen_want.gate) begin
          $display("%0t: gate expected %0b actual %0b", $time, seen_want.gate, out_gate);
          errors++;
        end
        if (out_cv_out !== seen_want.cv) begin
          $display("%0t: cv_out expected %0d actual %0d", $time, seen_want.cv, out_cv_out);
          errors++;
        end
        if (out_advanced !== seen_want.adv) begin
          $display("%0t: advanced expected %0b actual %0b", $time,
                   seen_want.adv, out_advanced);
          errors++;
        end
      end
      stall_draw = calm ? 0 : $urandom_range(0, 18);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  initial begin
    track_out_t             r;
    stim_row_t              row;
    bit                     prev_reg;
    bit                     live;
    int                     n_live;
    int                     n_phase;
    int                     sel;
    logic [1:0]             f;
    logic signed [CV_W-1:0] tv;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_RUN_MODE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_func        = FUNC_TICK;
    in_random_bit  = 1'b0;
    in_random_step = '0;
    in_table_index = '0;
    in_table_value = '0;

    m_mode   = MODE_FWD;
    m_len    = LOOP_LEN_RST;
    m_start  = START_RST;
    m_stride = STRIDE_RST;
    m_gates  = GATE_RST;
    m_hold   = 1'b0;
    m_quant  = 1'b0;
    m_en     = 1'b1;
    m_cnt    = '0;
    m_back   = 1'b0;
    m_held   = '0;
    foreach (m_table[i]) m_table[i] = CV_RESET;

    // defaults after reset, saturating writes, restart, no-op code
    rows.push_back(want_row(op_row(FUNC_TICK, 0, 0, 0, 0), 5'd1, 1'b1, CV_RESET, 1'b1));
    rows.push_back(want_row(op_row(FUNC_WRITE, 0, 0, 5'd1, 13'h0FFF),
                            5'd1, 1'b1, CV_RESET, 1'b0));
    rows.push_back(want_row(op_row(FUNC_WRITE, 1, 5'd31, 5'd2, 13'h1000),
                            5'd1, 1'b1, CV_RESET, 1'b0));
    rows.push_back(want_row(op_row(FUNC_RESTART, 0, 0, 0, 0), 5'd0, 1'b1, CV_RESET, 1'b1));
    rows.push_back(want_row(op_row(FUNC_TICK, 0, 0, 0, 0), 5'd1, 1'b1, CV_MAX, 1'b1));
    rows.push_back(want_row(op_row(FUNC_TICK, 0, 0, 0, 0), 5'd2, 1'b1, CV_MIN, 1'b1));
    rows.push_back(want_row(op_row(FUNC_NOP, 1, 5'd31, 5'd31, 13'h1FFF),
                            5'd2, 1'b1, CV_MIN, 1'b0));
    // quantize, half away from zero
    rows.push_back(reg_row(REG_QUANTIZE, 32'd1));
    rows.push_back(op_row(FUNC_WRITE, 0, 0, 5'd3, 13'sd1250));
    rows.push_back(op_row(FUNC_WRITE, 0, 0, 5'd4, -13'sd1250));
    rows.push_back(want_row(op_row(FUNC_TICK, 0, 0, 0, 0), 5'd3, 1'b1, 13'sd1300, 1'b1));
    rows.push_back(want_row(op_row(FUNC_TICK, 0, 0, 0, 0), 5'd4, 1'b1, -13'sd1300, 1'b1));
    // sample and hold on a gate-off step
    rows.push_back(reg_row(REG_SAMPLE_HOLD, 32'd1));
    rows.push_back(reg_row(REG_GATE, 32'hFFFF_FFDF));
    rows.push_back(want_row(op_row(FUNC_TICK, 0, 0, 0, 0), 5'd5, 1'b0, -13'sd1300, 1'b1));
    // disabled track
    rows.push_back(reg_row(REG_TRACK_EN, 32'd0));
    rows.push_back(want_row(op_row(FUNC_TICK, 0, 0, 0, 0), 5'd5, 1'b0, '0, 1'b0));
    rows.push_back(want_row(op_row(FUNC_WRITE, 0, 0, 5'd6, 13'sd100), 5'd5, 1'b0, '0, 1'b0));
    rows.push_back(want_row(op_row(FUNC_RESTART, 0, 0, 0, 0), 5'd5, 1'b0, '0, 1'b0));
    // backward restart and zero stride
    rows.push_back(reg_row(REG_TRACK_EN, 32'd1));
    rows.push_back(reg_row(REG_RUN_MODE, 32'(MODE_BWD)));
    rows.push_back(reg_row(REG_STRIDE, 32'd0));
    rows.push_back(want_row(op_row(FUNC_RESTART, 0, 0, 0, 0), 5'd7, 1'b1, CV_RESET, 1'b1));
    rows.push_back(want_row(op_row(FUNC_TICK, 0, 0, 0, 0), 5'd6, 1'b1, 13'sd100, 1'b1));
    // ping-pong bounce, oversized length and stride, offset wrap, shrink
    rows.push_back(reg_row(REG_RUN_MODE, 32'(MODE_PING_PONG)));
    rows.push_back(reg_row(REG_LOOP_LEN, 32'd40));
    rows.push_back(reg_row(REG_STRIDE, 32'd15));
    rows.push_back(reg_row(REG_START, 32'd31));
    rows.push_back(reg_row(REG_SAMPLE_HOLD, 32'd0));
    rows.push_back(reg_row(REG_QUANTIZE, 32'd0));
    repeat (4) rows.push_back(op_row(FUNC_TICK, 0, 0, 0, 0));
    rows.push_back(reg_row(REG_LOOP_LEN, 32'd4));
    rows.push_back(op_row(FUNC_TICK, 0, 0, 0, 0));
    rows.push_back(reg_row(REG_RUN_MODE, 32'(MODE_RND_WALK)));
    rows.push_back(op_row(FUNC_TICK, 0, 0, 0, 0));
    rows.push_back(op_row(FUNC_TICK, 1, 0, 0, 0));
    rows.push_back(reg_row(REG_RUN_MODE, 32'(MODE_RND_JUMP)));
    rows.push_back(reg_row(REG_LOOP_LEN, 32'd32));
    rows.push_back(op_row(FUNC_TICK, 0, 5'd31, 0, 0));
    rows.push_back(op_row(FUNC_RESTART, 0, 0, 0, 0));
    rows.push_back(reg_row(REG_RUN_MODE, 32'(MODE_UNUSED)));
    rows.push_back(op_row(FUNC_TICK, 0, 0, 0, 0));
    rows.push_back(op_row(FUNC_RESTART, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    prev_reg = 1'b0;
    foreach (rows[i]) begin
      row = rows[i];
      if (row.is_reg) begin
        if (!prev_reg) wait_idle();
        reg_write(row.idx, row.data);
      end else begin
        if (prev_reg) cfg_we <= 1'b0;
        send_item(row.func, row.rbit, row.rstep, row.tidx, row.tval, r);
        pending_q.push_back(row.typed ? row.want : r);
      end
      prev_reg = row.is_reg;
    end

    n_live = 0;
    while (n_live < TARGET_ITEMS) begin
      wait_idle();
      calm = ($urandom_range(0, 3) == 0);
      sel  = $urandom_range(0, 19);
      reg_write(REG_RUN_MODE, (sel < 18) ? sel % 5 : $urandom_range(5, 7));
      case ($urandom_range(0, 7))
        0:       reg_write(REG_LOOP_LEN, 32'd0);
        1:       reg_write(REG_LOOP_LEN, 32'd1);
        2:       reg_write(REG_LOOP_LEN, 32'd32);
        3:       reg_write(REG_LOOP_LEN, $urandom_range(33, 63));
        default: reg_write(REG_LOOP_LEN, $urandom_range(2, 31));
      endcase
      reg_write(REG_START, $urandom_range(0, 31));
      case ($urandom_range(0, 5))
        0:       reg_write(REG_STRIDE, 32'd0);
        1:       reg_write(REG_STRIDE, 32'd8);
        2:       reg_write(REG_STRIDE, $urandom_range(9, 15));
        default: reg_write(REG_STRIDE, $urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0:       reg_write(REG_GATE, 32'hFFFF_FFFF);
        1:       reg_write(REG_GATE, 32'h0000_0000);
        default: reg_write(REG_GATE, $urandom);
      endcase
      reg_write(REG_SAMPLE_HOLD, $urandom_range(0, 1));
      reg_write(REG_QUANTIZE, $urandom_range(0, 1));
      reg_write(REG_TRACK_EN, ($urandom_range(0, 9) != 0) ? 32'd1 : 32'd0);
      cfg_we <= 1'b0;

      n_phase = $urandom_range(15, 40);
      repeat (n_phase) begin
        sel = $urandom_range(0, 99);
        f   = (sel < 55) ? FUNC_TICK : (sel < 68) ? FUNC_RESTART :
              (sel < 95) ? FUNC_WRITE : FUNC_NOP;
        if ($urandom_range(0, 4) == 0) tv = CV_W'($urandom);
        else tv = CV_W'(int'($urandom_range(0, 7200)) - 3600);
        live = (f == FUNC_WRITE) || (m_en && (f == FUNC_TICK || f == FUNC_RESTART));
        send_item(f, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                  5'($urandom_range(0, 31)), tv, r);
        pending_q.push_back(r);
        if (live) n_live++;
      end
    end

    wait_idle();
    if (errors == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/cst_pkg.sv
rtl/cst_mod_unit.sv
rtl/cst_cv_mem.sv
rtl/cst_quant.sv
rtl/cyclic_step_sequencer_track.sv
sim/tb_cyclic_step_sequencer_track.sv
